// ===== design/mlpl_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpl_pkg: shared types and constants of the median level page lock
// Sample and level types, the link between sorter cells, the command word
// to the sorter chain, register indexes and the level mapping table.
// ----------------------------------------------------------------------------
package mlpl_pkg;

  localparam int SampleW   = 12;
  localparam int LevelW    = 7;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 2;
  localparam int NumBounds = 10;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [LevelW-1:0]  level_t;

  // item kinds
  typedef enum logic {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } opcode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgAlarmThr  = 2'd0,
    CfgStableBlk = 2'd1,
    CfgSwitchTck = 2'd2
  } cfg_idx_e;

  // what one cell hands to its upper neighbour
  typedef struct packed {
    logic    gt;   // cell holds a valid value above the incoming sample
    sample_t val;  // value held by the cell
  } mlpl_link_t;

  // command word from the controller to the sorter chain
  typedef struct packed {
    logic ins;  // insert the sample on the chain input
    logic sel;  // capture the median and empty the chain
  } chain_cmd_t;

  // thresholds, highest first; bound k maps to level 100 - 10k
  localparam sample_t LevelBound [NumBounds] = '{
    12'd2450, 12'd1800, 12'd1150, 12'd830, 12'd600,
    12'd500,  12'd430,  12'd380,  12'd320, 12'd270
  };

  // map a median to a level: the first bound reached wins
  function automatic level_t map_level(sample_t v);
    level_t lvl;
    lvl = '0;
    for (int k = NumBounds - 1; k >= 0; k--) begin
      if (v >= LevelBound[k]) begin
        lvl = LevelW'(100 - 10 * k);
      end
    end
    return lvl;
  endfunction

endpackage

// ===== design/mlpl_cell.sv =====
// ----------------------------------------------------------------------------
// mlpl_cell: one cell of the insertion sorter
// Holds one sample. On an insert it keeps its value, takes the value of its
// lower neighbour (shift up) or takes the new sample, so the row stays sorted.
// ----------------------------------------------------------------------------
module mlpl_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                valid_i,
  input  mlpl_pkg::sample_t   x_i,
  input  mlpl_pkg::mlpl_link_t prev_i,
  output mlpl_pkg::mlpl_link_t next_o
);
  import mlpl_pkg::*;

  sample_t val_q;
  logic    gt;

  // flag a valid value above the new sample
  assign gt          = valid_i && (val_q > x_i);
  assign next_o.gt   = gt;
  assign next_o.val  = val_q;

  // keep, shift up from below, or take the new sample
  always_ff @(posedge clk_i) begin
    if (en_i && (gt || !valid_i)) begin
      val_q <= prev_i.gt ? prev_i.val : x_i;
    end
  end

endmodule

// ===== design/mlpl_chain.sv =====
// ----------------------------------------------------------------------------
// mlpl_chain: row of sorter cells with fill count and median capture
// Absorbs one sample per cycle in sorted order and, on request, registers
// the cell at index fill/2 and empties the row.
// ----------------------------------------------------------------------------
module mlpl_chain #(
  parameter int Depth = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlpl_pkg::chain_cmd_t  cmd_i,
  input  mlpl_pkg::sample_t     x_i,
  output mlpl_pkg::sample_t     med_o
);
  import mlpl_pkg::*;

  localparam int FillW = $clog2(Depth + 1);
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [FillW-1:0] fill_q, fill_d;
  logic             full;
  logic             en;
  logic [IdxW-1:0]  med_idx;
  sample_t          med_sel;
  sample_t          med_q;
  mlpl_link_t       links [Depth];

  // drop samples once the row is full
  assign full = (fill_q == FillW'(Depth));
  assign en   = cmd_i.ins && !full;

  // build the row of cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic       valid;
    mlpl_link_t prev;
    assign valid = (FillW'(i) < fill_q);
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = links[i-1];
    end
    mlpl_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .valid_i (valid),
      .x_i     (x_i),
      .prev_i  (prev),
      .next_o  (links[i])
    );
  end

  // pick the middle cell
  assign med_idx = IdxW'(fill_q >> 1);

  always_comb begin
    med_sel = '0;
    for (int i = 0; i < Depth; i++) begin
      if (IdxW'(i) == med_idx) begin
        med_sel = med_sel | links[i].val;
      end
    end
  end

  // advance the fill count, clear it on capture
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.sel) begin
      fill_d = '0;
    end else if (en) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // hold the captured median
  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      med_q <= med_sel;
    end
  end

  assign med_o = med_q;

endmodule

// ===== design/median_level_page_lock.sv =====
// ----------------------------------------------------------------------------
// median_level_page_lock: median filtered water level with page lock
// Input channel: an item (opcode, sample, block_end) is taken on a clock
// edge with start high and busy low. Opcode sample feeds a sorted cell row;
// opcode tick advances the page timer.
// Result channel: every item gives one word on the result ports, marked by
// res_strobe_o for one cycle; the receiver takes it in that cycle and
// cannot stall the block.
// Timing: a tick or a sample without block_end gives its word in the cycle
// after acceptance and busy stays low, so one such item per cycle.
// A sample with block_end holds busy through StSel (median capture from
// the cell row) and StMap (level mapping), and its word appears after
// StMap, so no new item is taken until then. While busy is low the row
// absorbs one sample per cycle; the median select and the ten threshold
// compares each get a state of their own.
// Configuration: a separate write channel, always ready; write only while
// idle. Reset: row empty, level, median, lock, timer and page cleared,
// registers at their defaults (alarm 80, stable 10, switch 5000).
// ----------------------------------------------------------------------------
module median_level_page_lock #(
  parameter int SAMPLES_PER_BLOCK = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  mlpl_pkg::sample_t             sample_i,
  input  logic                          block_end_i,
  // result channel
  output logic                          res_strobe_o,
  output mlpl_pkg::level_t              level_o,
  output mlpl_pkg::sample_t             median_value_o,
  output logic                          level_done_o,
  output logic                          page_o,
  output logic                          locked_o,
  output logic                          alarm_o,
  output logic                          redraw_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mlpl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mlpl_pkg::CfgDataW-1:0] cfg_data_i
);
  import mlpl_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSel,
    StMap
  } state_e;

  state_e       state_q;
  logic         accept;
  chain_cmd_t   cmd;
  sample_t      chain_med;
  level_t       new_level;

  level_t       level_q;
  sample_t      median_q;
  logic         lock_q;
  logic [7:0]   stable_q;
  logic [7:0]   stable_inc;
  logic         page_q;
  logic [15:0]  elapsed_q;
  logic [15:0]  elapsed_inc;
  logic         toggle;

  level_t       alarm_thr_q;
  logic [7:0]   stable_blk_q;
  logic [15:0]  switch_tck_q;

  logic         strobe_q;
  logic         done_q;
  logic         redraw_q;

  // take an item when not busy
  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // drive the sorter chain
  assign cmd.ins = accept && (opcode_i == OpSample);
  assign cmd.sel = (state_q == StSel);

  mlpl_chain #(
    .Depth (SAMPLES_PER_BLOCK)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (sample_i),
    .med_o  (chain_med)
  );

  // map the captured median
  assign new_level  = map_level(chain_med);
  assign stable_inc = stable_q + 8'd1;

  // saturating tick count and page toggle test
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : (elapsed_q + 16'd1);
  assign toggle      = !lock_q && (elapsed_inc >= switch_tck_q);

  // hold state, registers and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      level_q      <= '0;
      median_q     <= '0;
      lock_q       <= 1'b0;
      stable_q     <= '0;
      page_q       <= 1'b0;
      elapsed_q    <= '0;
      alarm_thr_q  <= LevelW'(80);
      stable_blk_q <= 8'd10;
      switch_tck_q <= 16'd5000;
      strobe_q     <= 1'b0;
      done_q       <= 1'b0;
      redraw_q     <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      done_q   <= 1'b0;
      redraw_q <= 1'b0;

      // configuration word
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgAlarmThr:  alarm_thr_q  <= cfg_data_i[LevelW-1:0];
          CfgStableBlk: stable_blk_q <= cfg_data_i[7:0];
          CfgSwitchTck: switch_tck_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (opcode_i == OpTick) begin
              strobe_q <= 1'b1;
              if (toggle) begin
                page_q    <= ~page_q;
                elapsed_q <= '0;
                redraw_q  <= 1'b1;
              end else begin
                elapsed_q <= elapsed_inc;
              end
            end else if (block_end_i) begin
              state_q <= StSel;
            end else begin
              strobe_q <= 1'b1;
            end
          end
        end
        StSel: begin
          state_q <= StMap;
        end
        StMap: begin
          state_q  <= StIdle;
          median_q <= chain_med;
          strobe_q <= 1'b1;
          done_q   <= 1'b1;
          if (new_level != level_q) begin
            level_q  <= new_level;
            lock_q   <= 1'b1;
            stable_q <= '0;
            redraw_q <= 1'b1;
            if (page_q) begin
              page_q    <= 1'b0;
              elapsed_q <= '0;
            end
          end else if (lock_q && (stable_q < stable_blk_q)) begin
            stable_q <= stable_inc;
            if (stable_inc >= stable_blk_q) begin
              lock_q    <= 1'b0;
              elapsed_q <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // result word
  assign res_strobe_o   = strobe_q;
  assign level_o        = level_q;
  assign median_value_o = median_q;
  assign level_done_o   = done_q;
  assign page_o         = page_q;
  assign locked_o       = lock_q;
  assign alarm_o        = (level_q >= alarm_thr_q);
  assign redraw_o       = redraw_q;
  assign cfg_ready_o    = 1'b1;

  // a block end runs capture then mapping
  a_sel_then_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSel) |=> (state_q == StMap))
    else $error("median capture not followed by mapping");

  // a completed block always gives a result word
  a_map_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMap) |=> (res_strobe_o && level_done_o))
    else $error("block end without result word");

  // a level change locks the water page
  a_change_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_done_o && redraw_o) |-> (locked_o && !page_o))
    else $error("level change did not lock the water page");

  // no item is taken while a block end is in progress
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept)
    else $error("item accepted while busy");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the median level page lock
// Drives sample and tick words, predicts every result word from an internal
// copy of the sorter row, level, lock, page and timer state, and compares
// each strobed word field by field. A short directed table covers reset
// values, sample extremes, short, odd and overflowing blocks and block end
// on a tick. Random well-formed blocks, tick bursts and noise then run
// under several register settings, including the extremes.
// ----------------------------------------------------------------------------
module testbench;
  import mlpl_pkg::*;

  localparam int BlockDepth   = 16;
  localparam int IdleLimit    = 1000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 150;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    level_t  level;
    sample_t median;
    logic    done;
    logic    page;
    logic    locked;
    logic    alarm;
    logic    redraw;
  } page_word_t;

  typedef struct {
    opcode_e    op;
    sample_t    smp;
    logic       last;
    bit         typed;
    page_word_t word;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic                opcode_i    = 1'b0;
  sample_t             sample_i    = '0;
  logic                block_end_i = 1'b0;
  logic                res_strobe_o;
  level_t              level_o;
  sample_t             median_value_o;
  logic                level_done_o;
  logic                page_o;
  logic                locked_o;
  logic                alarm_o;
  logic                redraw_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  median_level_page_lock #(
    .SAMPLES_PER_BLOCK(BlockDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .sample_i       (sample_i),
    .block_end_i    (block_end_i),
    .res_strobe_o   (res_strobe_o),
    .level_o        (level_o),
    .median_value_o (median_value_o),
    .level_done_o   (level_done_o),
    .page_o         (page_o),
    .locked_o       (locked_o),
    .alarm_o        (alarm_o),
    .redraw_o       (redraw_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted block state
  sample_t     row_cells [BlockDepth];
  int unsigned row_fill   = 0;
  level_t      cur_level  = '0;
  sample_t     cur_median = '0;
  logic        cur_lock   = 1'b0;
  logic [7:0]  stable_cnt = '0;
  logic        cur_page   = 1'b0;
  logic [15:0] elapsed    = '0;
  logic [6:0]  alarm_thr  = 7'd80;
  logic [7:0]  stable_lim = 8'd10;
  logic [15:0] switch_lim = 16'd5000;

  page_word_t  expected_words [$];
  stim_row_t   directed_rows [$];
  int          errors      = 0;
  int          n_items     = 0;
  int          n_blocks    = 0;
  int          n_redraws   = 0;
  int          n_releases  = 0;
  int          n_cfg       = 0;
  int          idle_pct    = 34;
  int          idle_cycles = 0;
  sample_t     block_target = 12'd600;

  // map a median onto the level scale, highest bound first
  function automatic level_t level_of(sample_t v);
    level_t lvl;
    bit     hit;
    lvl = '0;
    hit = 1'b0;
    for (int k = 0; k < NumBounds; k++) begin
      if (!hit && v >= LevelBound[k]) begin
        lvl = level_t'(100 - 10 * k);
        hit = 1'b1;
      end
    end
    return lvl;
  endfunction

  // advance the predicted state by one word and return the result word
  function automatic page_word_t predict_page_word(opcode_e op, sample_t smp, logic last);
    page_word_t w;
    int         pos;
    level_t     nl;
    w = '0;
    if (op == OpSample) begin
      // insert in order; drop samples once the row is full
      if (row_fill < BlockDepth) begin
        pos = row_fill;
        while (pos > 0 && row_cells[pos-1] > smp) begin
          row_cells[pos] = row_cells[pos-1];
          pos--;
        end
        row_cells[pos] = smp;
        row_fill++;
      end
      if (last) begin
        cur_median = row_cells[row_fill / 2];
        row_fill   = 0;
        nl         = level_of(cur_median);
        w.done     = 1'b1;
        n_blocks++;
        if (nl != cur_level) begin
          cur_level  = nl;
          cur_lock   = 1'b1;
          stable_cnt = '0;
          if (cur_page) begin
            cur_page = 1'b0;
            elapsed  = '0;
          end
          w.redraw = 1'b1;
        end else if (cur_lock && stable_cnt < stable_lim) begin
          stable_cnt++;
          if (stable_cnt >= stable_lim) begin
            cur_lock = 1'b0;
            elapsed  = '0;
            n_releases++;
          end
        end
      end
    end else begin
      // saturating tick count; toggle the unlocked page at the switch time
      if (elapsed != 16'hFFFF) elapsed++;
      if (!cur_lock && elapsed >= switch_lim) begin
        cur_page = ~cur_page;
        elapsed  = '0;
        w.redraw = 1'b1;
      end
    end
    w.level  = cur_level;
    w.median = cur_median;
    w.page   = cur_page;
    w.locked = cur_lock;
    w.alarm  = (cur_level >= alarm_thr);
    return w;
  endfunction

  // offer one word, hold it until taken, then record the expected result
  task automatic send_item(opcode_e op, sample_t smp, logic last, bit typed,
                           page_word_t word);
    page_word_t pw;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    sample_i    <= smp;
    block_end_i <= last;
    do @(posedge clk_i); while (busy);
    pw = predict_page_word(op, smp, last);
    expected_words.push_back(typed ? word : pw);
    n_items++;
  endtask

  task automatic add_row(opcode_e op, sample_t smp, logic last, bit typed,
                         page_word_t word);
    stim_row_t r;
    r.op    = op;
    r.smp   = smp;
    r.last  = last;
    r.typed = typed;
    r.word  = word;
    directed_rows.push_back(r);
  endtask

  // drop start, wait for every outstanding result, then let the pipe empty
  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write; valid stays high so writes can run back to back
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgAlarmThr:  alarm_thr  = data[6:0];
      CfgStableBlk: stable_lim = data[7:0];
      CfgSwitchTck: switch_lim = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  // one block: mostly the target value so the median settles on it
  task automatic send_block();
    int      len;
    sample_t smp;
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(9))
        0:       block_target = '0;
        1:       block_target = 12'hFFF;
        2, 3:    block_target = sample_t'($urandom_range(4095));
        default: block_target = LevelBound[$urandom_range(NumBounds - 1)]
                                - sample_t'($urandom_range(1));
      endcase
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(OpTick, sample_t'($urandom_range(4095)), 1'($urandom_range(1)),
                  1'b0, '0);
      end
      smp = ($urandom_range(99) < 65) ? block_target : sample_t'($urandom_range(4095));
      send_item(OpSample, smp, (i == len - 1), 1'b0, '0);
    end
  endtask

  // random part: blocks, tick bursts and noise until the item goal
  task automatic run_random(int goal);
    int roll;
    while (n_items < goal) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        send_block();
      end else if (roll < 88) begin
        repeat ($urandom_range(40, 1)) begin
          send_item(OpTick, sample_t'($urandom_range(4095)), 1'($urandom_range(1)),
                    1'b0, '0);
        end
      end else begin
        send_item(opcode_e'($urandom_range(1)), sample_t'($urandom_range(4095)),
                  1'($urandom_range(1)), 1'b0, '0);
      end
    end
  endtask

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // check every strobed word against the oldest expectation
  always @(posedge clk_i) begin : check_words
    page_word_t got;
    page_word_t want;
    if (rst_ni && res_strobe_o) begin
      got = {level_o, median_value_o, level_done_o, page_o, locked_o, alarm_o, redraw_o};
      if (got.redraw === 1'b1) n_redraws++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, got level %0d median %0d",
                 $time, got.level, got.median);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          errors++;
          report_field("level", want.level, got.level);
          report_field("median_value", want.median, got.median);
          report_field("level_done", want.done, got.done);
          report_field("page", want.page, got.page);
          report_field("locked", want.locked, got.locked);
          report_field("alarm", want.alarm, got.alarm);
          report_field("redraw", want.redraw, got.redraw);
          if ($isunknown(got)) begin
            $display("%0t: unknown bits in word, expected %h, got %h", $time, want, got);
          end
        end
      end
    end
  end

  // end the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles at %0t", IdleLimit, $time);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pcts [4];
    pcts = '{34, 45, 0, 0};

    // directed table; typed words hold at the reset register defaults
    add_row(OpTick, 12'hABC, 1'b0, 1'b1,
            {7'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(OpSample, 12'hFFF, 1'b1, 1'b1,
            {7'd100, 12'd4095, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1});
    add_row(OpSample, 12'h000, 1'b1, 1'b1,
            {7'd0, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(OpTick, 12'hFFF, 1'b1, 1'b0, '0);
    add_row(OpSample, 12'd600, 1'b0, 1'b0, '0);
    add_row(OpSample, 12'd100, 1'b0, 1'b0, '0);
    add_row(OpSample, 12'd2450, 1'b1, 1'b0, '0);
    add_row(OpSample, 12'd270, 1'b0, 1'b0, '0);
    add_row(OpSample, 12'd269, 1'b1, 1'b0, '0);
    // overflowing block: the marked last sample is dropped but closes it
    for (int i = 0; i < BlockDepth; i++) begin
      add_row(OpSample, sample_t'(3000 - 170 * i), 1'b0, 1'b0, '0);
    end
    add_row(OpSample, 12'd5, 1'b1, 1'b0, '0);

    // hold reset, then release on a clock edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].word);
    end

    // random phases under different register settings and idling
    for (int p = 0; p < 4; p++) begin
      drain_and_settle();
      case (p)
        0: begin
          write_cfg(CfgAlarmThr, {9'($urandom_range(511)), 7'd127});
          write_cfg(CfgStableBlk, {8'($urandom_range(255)), 8'd1});
          write_cfg(CfgSwitchTck, 16'd0);
          write_cfg(CfgSpare, 16'($urandom_range(65535)));
        end
        1: begin
          write_cfg(CfgAlarmThr, {9'($urandom_range(511)), 7'd100});
          write_cfg(CfgStableBlk, {8'($urandom_range(255)), 8'd0});
          write_cfg(CfgSwitchTck, 16'hFFFF);
        end
        2: begin
          write_cfg(CfgAlarmThr, {9'($urandom_range(511)), 7'd0});
          write_cfg(CfgStableBlk, {8'($urandom_range(255)), 8'd255});
          write_cfg(CfgSwitchTck, 16'd1);
        end
        default: begin
          write_cfg(CfgAlarmThr, {9'($urandom_range(511)), 7'($urandom_range(100))});
          write_cfg(CfgStableBlk, {8'($urandom_range(255)), 8'($urandom_range(5, 2))});
          write_cfg(CfgSwitchTck, 16'($urandom_range(30, 2)));
        end
      endcase
      cfg_valid_i <= 1'b0;
      repeat (2) @(posedge clk_i);
      idle_pct = pcts[p];
      run_random(n_items + PhaseItems);
    end

    drain_and_settle();
    $display("run covered %0d words, %0d closed blocks, %0d redraws, %0d lock releases",
             n_items, n_blocks, n_redraws, n_releases);
    $display("%0d register writes over four settings, %0d mismatches", n_cfg, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mlpl_pkg.sv
design/mlpl_cell.sv
design/mlpl_chain.sv
design/median_level_page_lock.sv
tb/sv/testbench.sv
